FILE: hw/rtl/tzwm_pkg.sv
// ============================================================================
// tzwm_pkg: shared types and constants of the two-zone window minimum block
// Holds the result status codes, configuration register indexes and the
// control word that the top level broadcasts to every cell of the chain.
// ============================================================================
`default_nettype none

package tzwm_pkg;

  localparam int DIST_W = 16;

  // Result status codes.
  localparam logic [1:0] ST_UPDATED = 2'd0;
  localparam logic [1:0] ST_FILLING = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_PERSON_LIMIT = 1'b0;
  localparam logic CFG_DOOR_LIMIT   = 1'b1;

  // Register values after reset.
  localparam logic [DIST_W-1:0] PERSON_LIMIT_RST = 16'd1000;
  localparam logic [DIST_W-1:0] DOOR_LIMIT_RST   = 16'd0;

  // Control word seen by every cell.
  typedef struct packed {
    logic shift_en;    // shift the selected zone's window by one place
    logic shift_zone;  // zone whose window shifts
    logic sweep_zone;  // zone whose samples feed the running minimum
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tzwm_cell.sv
// ============================================================================
// tzwm_cell: one window slot of the minimum chain
// Stores one sample for each zone, shifts toward its left neighbor and
// passes a running minimum to its right neighbor every cycle.
// ============================================================================
`default_nettype none

module tzwm_cell
  import tzwm_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [DIST_W-1:0] sample_in,
  input  wire logic [DIST_W-1:0] min_in,
  output logic      [DIST_W-1:0] sample_out,
  output logic      [DIST_W-1:0] min_out
);

  logic [DIST_W-1:0] s0_r, s0_nxt;
  logic [DIST_W-1:0] s1_r, s1_nxt;
  logic [DIST_W-1:0] min_r, min_nxt;
  logic [DIST_W-1:0] swept;

  always_comb begin
    s0_nxt = s0_r;
    s1_nxt = s1_r;
    if (ctrl.shift_en) begin
      if (ctrl.shift_zone) begin
        s1_nxt = sample_in;
      end else begin
        s0_nxt = sample_in;
      end
    end
    swept   = ctrl.sweep_zone ? s1_r : s0_r;
    min_nxt = (swept < min_in) ? swept : min_in;
  end

  always_ff @(posedge clk) begin
    s0_r  <= s0_nxt;
    s1_r  <= s1_nxt;
    min_r <= min_nxt;
  end

  assign sample_out = ctrl.shift_zone ? s1_r : s0_r;
  assign min_out    = min_r;

endmodule

`default_nettype wire

FILE: hw/rtl/two_zone_window_min_occupancy.sv
// ============================================================================
// two_zone_window_min_occupancy: two-zone sliding-window minimum occupancy
// Keeps the last WINDOW distances of each zone in a chain of cells and
// flags a zone occupied when its window minimum lies between two limits.
// ============================================================================
// Each input word is one ranging sample for zone 0 or 1, or a timeout, and
// gives exactly one result word. A timeout returns status 2 and the current
// occupancy without touching any state. While a zone has stored fewer than
// WINDOW samples, its sample is kept and status 1 (filling) is returned; the
// sample that completes the window still reports filling. Once the window is
// full, the new sample pushes out the oldest one, a running minimum travels
// down the cell chain, and the zone's occupancy bit is set when that minimum
// is strictly above door_limit and strictly below person_limit. A timeout or
// filling word is answered at the edge that accepts it. A full-window word
// sends the minimum once through the WINDOW cells into a combinational limit
// compare; in_ready stays low until the result enters the output register.
// A finished result waits there, and the next word can be accepted in the
// same cycle that the waiting result is taken. The user must write the
// limits through the cfg_ port (index 0 person_limit, index 1 door_limit)
// only while the block is idle; the block itself does not enforce this.
// ============================================================================
`default_nettype none

module two_zone_window_min_occupancy
  import tzwm_pkg::*;
#(
  parameter int WINDOW = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Input channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_zone,
  input  wire logic [DIST_W-1:0] in_distance,
  input  wire logic              in_timed_out,
  // Result channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [1:0]        out_status,
  output logic      [1:0]        out_occupancy,
  output logic                   out_changed,
  output logic      [DIST_W-1:0] out_zone_minimum,
  // Configuration port
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [DIST_W-1:0] cfg_wdata
);

  localparam int FW = $clog2(WINDOW + 1);  // fill counter and sweep counter

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SWEEP = 1'b1;

  // Control state.
  logic          state_r, state_nxt;
  logic [FW-1:0] fill_r [2];
  logic [FW-1:0] fill_nxt [2];
  logic [FW-1:0] cnt_r, cnt_nxt;
  logic          zone_r, zone_nxt;
  logic [1:0]    occ_r, occ_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Configuration.
  logic [DIST_W-1:0] person_r, person_nxt;
  logic [DIST_W-1:0] door_r, door_nxt;

  // Result payload.
  logic [1:0]        status_r, status_nxt;
  logic [1:0]        res_occ_r, res_occ_nxt;
  logic              changed_r, changed_nxt;
  logic [DIST_W-1:0] zmin_r, zmin_nxt;

  // Cell chain.
  cell_ctrl_t        ctrl;
  logic [DIST_W-1:0] samp_w [WINDOW];
  logic [DIST_W-1:0] min_w  [WINDOW];

  logic              accept;
  logic              out_free;
  logic              zone_full;
  logic [DIST_W-1:0] win_min;
  logic              hit;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign zone_full = (fill_r[in_zone] == FW'(WINDOW));

  // The minimum leaves the last cell; compare it against both limits.
  assign win_min = min_w[WINDOW-1];
  assign hit     = (win_min < person_r) && (win_min > door_r);

  assign ctrl.shift_en   = accept && !in_timed_out;
  assign ctrl.shift_zone = in_zone;
  assign ctrl.sweep_zone = zone_r;

  // New samples enter at the top cell and age toward cell 0; the running
  // minimum starts at cell 0 with the largest distance and flows upward.
  for (genvar gi = 0; gi < WINDOW; gi++) begin : g_cell
    logic [DIST_W-1:0] s_in;
    logic [DIST_W-1:0] m_in;

    if (gi == WINDOW - 1) begin : g_top
      assign s_in = in_distance;
    end else begin : g_mid
      assign s_in = samp_w[gi+1];
    end

    if (gi == 0) begin : g_first
      assign m_in = '1;
    end else begin : g_rest
      assign m_in = min_w[gi-1];
    end

    tzwm_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .sample_in  (s_in),
      .min_in     (m_in),
      .sample_out (samp_w[gi]),
      .min_out    (min_w[gi])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt[0]   = fill_r[0];
    fill_nxt[1]   = fill_r[1];
    cnt_nxt       = cnt_r;
    zone_nxt      = zone_r;
    occ_nxt       = occ_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    res_occ_nxt   = res_occ_r;
    changed_nxt   = changed_r;
    zmin_nxt      = zmin_r;

    if (accept) begin
      if (in_timed_out) begin
        out_valid_nxt = 1'b1;
        status_nxt    = ST_TIMEOUT;
        res_occ_nxt   = occ_r;
        changed_nxt   = 1'b0;
        zmin_nxt      = '0;
      end else if (!zone_full) begin
        fill_nxt[in_zone] = fill_r[in_zone] + 1'b1;
        out_valid_nxt     = 1'b1;
        status_nxt        = ST_FILLING;
        res_occ_nxt       = occ_r;
        changed_nxt       = 1'b0;
        zmin_nxt          = '0;
      end else begin
        state_nxt = ST_SWEEP;
        zone_nxt  = in_zone;
        cnt_nxt   = '0;
      end
    end else if (state_r == ST_SWEEP) begin
      if (cnt_r != FW'(WINDOW)) begin
        cnt_nxt = cnt_r + 1'b1;
      end else if (out_free) begin
        occ_nxt[zone_r] = hit;
        out_valid_nxt   = 1'b1;
        status_nxt      = ST_UPDATED;
        res_occ_nxt     = occ_nxt;
        changed_nxt     = (occ_nxt != occ_r);
        zmin_nxt        = win_min;
        state_nxt       = ST_IDLE;
      end
    end
  end

  always_comb begin
    person_nxt = person_r;
    door_nxt   = door_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PERSON_LIMIT: person_nxt = cfg_wdata;
        CFG_DOOR_LIMIT:   door_nxt   = cfg_wdata;
        default:          person_nxt = person_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r[0]   <= '0;
      fill_r[1]   <= '0;
      cnt_r       <= '0;
      zone_r      <= 1'b0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
      person_r    <= PERSON_LIMIT_RST;
      door_r      <= DOOR_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      fill_r[0]   <= fill_nxt[0];
      fill_r[1]   <= fill_nxt[1];
      cnt_r       <= cnt_nxt;
      zone_r      <= zone_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
      person_r    <= person_nxt;
      door_r      <= door_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    res_occ_r <= res_occ_nxt;
    changed_r <= changed_nxt;
    zmin_r    <= zmin_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_occupancy    = res_occ_r;
  assign out_changed      = changed_r;
  assign out_zone_minimum = zmin_r;

  // A fill count never passes the window length.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r[0] <= FW'(WINDOW)) && (fill_r[1] <= FW'(WINDOW)))
    else $error("fill count beyond window length");

  // A sample for a full zone starts a minimum pass.
  a_sweep_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_timed_out && zone_full |=> state_r == ST_SWEEP)
    else $error("full-window sample did not start a sweep");

  // A finished pass leaves an updated result in the output register.
  a_sweep_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SWEEP && state_nxt == ST_IDLE |=>
      out_valid_r && status_r == ST_UPDATED && res_occ_r == occ_r)
    else $error("sweep ended without an updated result");

  // Occupancy moves only together with a result that reports the change.
  a_occ_change: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && occ_r != $past(occ_r) |-> out_valid_r && changed_r)
    else $error("occupancy changed without a changed result");

endmodule

`default_nettype wire
